// ----- hw/rtl/fpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Fixed partition allocator package
// Shared widths, codes, types and reset capacities for the allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

  localparam int NUM_PARTS = 5;
  localparam int SIZE_W    = 16;
  localparam int IDX_W     = 3;
  localparam int MODE_W    = 2;
  localparam int CNT_W     = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;

  // Stream payload widths (padded to whole bytes)
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_FIT_MODE  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_SIZE_BASE = IDX_W'(1);

  // Input item kinds
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIRST = 2'd0,
    MODE_BEST  = 2'd1,
    MODE_WORST = 2'd2,
    MODE_NEXT  = 2'd3
  } fit_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE,
    ST_DONE
  } alloc_state_t;

  typedef logic [NUM_PARTS-1:0][SIZE_W-1:0] part_sizes_t;

  // Candidate and current pick seen by the compare unit
  typedef struct packed {
    fit_mode_t         mode;
    logic [SIZE_W-1:0] req_size;
    logic [SIZE_W-1:0] cand_size;
    logic              cand_busy;
    logic              have_pick;
    logic [SIZE_W-1:0] pick_size;
  } fit_cmp_req_t;

  // Compare unit verdict
  typedef struct packed {
    logic fits;
    logic take;
  } fit_cmp_rsp_t;

  // Capacity of each partition after reset
  function automatic logic [SIZE_W-1:0] size_reset(input int idx);
    logic [SIZE_W-1:0] val;
    unique case (idx)
      0:       val = SIZE_W'(100);
      1:       val = SIZE_W'(200);
      2:       val = SIZE_W'(102);
      3:       val = SIZE_W'(202);
      4:       val = SIZE_W'(622);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ----- hw/rtl/fixed_partition_fit_allocator.sv -----
// ----------------------------------------------------------------------------
// Fixed partition fit allocator
// An allocate scans every partition in turn through the shared compare unit,
// then commits; a free goes straight to the commit state. A stalled result
// holds the commit state until it drains. Input is taken only when the
// sequencer is idle, so a new item waits until the last one is through,
// while a prior result may still wait at the output.
// Reset (rst, synchronous): all partitions free, fit mode first fit,
// capacities 100/200/102/202/622, next-fit start at partition 0.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [fpfa_pkg::IDX_W-1:0]          cfg_index,
  input  logic [fpfa_pkg::SIZE_W-1:0]         cfg_data,
  // Input stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [fpfa_pkg::IN_DATA_W-1:0]      s_tdata,  // req_size[15:0], free_index[18:16]
  input  logic                                s_tuser,  // func
  // Result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [fpfa_pkg::OUT_DATA_W-1:0]     m_tdata   // success[0], part_index[3:1],
                                                        // part_size[19:4]
);
  import fpfa_pkg::*;

  // Configuration registers
  fit_mode_t         fit_mode;
  part_sizes_t       part_sizes;

  // Allocator state
  logic [NUM_PARTS-1:0] part_busy;
  logic [IDX_W-1:0]     next_start;

  // Sequencer
  alloc_state_t      state, state_next;
  logic [CNT_W-1:0]  scan_cnt;
  logic [IDX_W-1:0]  cur_idx;
  logic              is_free;
  logic [SIZE_W-1:0] req_size;
  logic              have_pick;
  logic [IDX_W-1:0]  pick_idx;
  logic [SIZE_W-1:0] pick_size;

  logic              in_xfer;
  logic              out_free;
  logic              scan_last;
  logic              do_scan;
  logic              do_free;
  logic              do_finish;
  logic [SIZE_W-1:0] cur_size;
  logic              cur_busy;
  logic [IDX_W-1:0]  start_idx;
  logic [IDX_W-1:0]  in_free_idx;
  fit_cmp_req_t      cmp_req;
  fit_cmp_rsp_t      cmp_rsp;

  assign in_xfer     = s_tvalid && s_tready;
  assign out_free    = !m_tvalid || m_tready;
  assign scan_last   = (scan_cnt == CNT_W'(NUM_PARTS - 1));
  assign in_free_idx = s_tdata[SIZE_W +: IDX_W];

  // Stale next-fit start wraps to partition 0
  assign start_idx = (fit_mode == MODE_NEXT && next_start < IDX_W'(NUM_PARTS)) ?
                     next_start : '0;

  // Single read port onto the partition table
  always_comb begin
    cur_size = '0;
    cur_busy = 1'b1;
    for (int i = 0; i < NUM_PARTS; i++) begin
      if (cur_idx == IDX_W'(i)) begin
        cur_size = part_sizes[i];
        cur_busy = part_busy[i];
      end
    end
  end

  // Shared compare unit
  assign cmp_req = '{mode: fit_mode, req_size: req_size, cand_size: cur_size,
                     cand_busy: cur_busy, have_pick: have_pick, pick_size: pick_size};

  fpfa_fit_cmp u_fit_cmp (
    .req (cmp_req),
    .rsp (cmp_rsp)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = (s_tuser == FUNC_FREE) ? ST_FREE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_FREE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_tready  = (state == ST_IDLE);
    do_scan   = (state == ST_SCAN);
    do_free   = (state == ST_FREE);
    do_finish = (state == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode <= MODE_FIRST;
      for (int i = 0; i < NUM_PARTS; i++) begin
        part_sizes[i] <= size_reset(i);
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_FIT_MODE) begin
        fit_mode <= fit_mode_t'(cfg_data[MODE_W-1:0]);
      end
      for (int i = 0; i < NUM_PARTS; i++) begin
        if (cfg_index == REG_SIZE_BASE + IDX_W'(i)) begin
          part_sizes[i] <= cfg_data;
        end
      end
    end
  end

  // Scan sequencer and pick register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      is_free   <= (s_tuser == FUNC_FREE);
      req_size  <= s_tdata[SIZE_W-1:0];
      have_pick <= 1'b0;
      pick_idx  <= '0;
      pick_size <= '0;
      scan_cnt  <= '0;
      cur_idx   <= (s_tuser == FUNC_FREE) ? in_free_idx : start_idx;
    end else if (do_scan) begin
      if (cmp_rsp.take) begin
        have_pick <= 1'b1;
        pick_idx  <= cur_idx;
        pick_size <= cur_size;
      end
      scan_cnt <= scan_cnt + CNT_W'(1);
      cur_idx  <= (cur_idx == IDX_W'(NUM_PARTS - 1)) ? '0 : cur_idx + IDX_W'(1);
    end else if (do_free) begin
      if (cur_idx < IDX_W'(NUM_PARTS)) begin
        have_pick <= 1'b1;
        pick_idx  <= cur_idx;
        pick_size <= cur_size;
      end
    end
  end

  // Commit: busy flags and next-fit start
  always_ff @(posedge clk) begin
    if (rst) begin
      part_busy  <= '0;
      next_start <= '0;
    end else if (do_finish && have_pick) begin
      for (int i = 0; i < NUM_PARTS; i++) begin
        if (pick_idx == IDX_W'(i)) begin
          part_busy[i] <= !is_free;
        end
      end
      if (!is_free && fit_mode == MODE_NEXT) begin
        next_start <= pick_idx;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (do_finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_finish) begin
      m_tdata <= {(OUT_DATA_W - 1 - IDX_W - SIZE_W)'(0),
                  have_pick ? pick_size : SIZE_W'(0),
                  have_pick ? pick_idx : IDX_W'(0),
                  have_pick};
    end
  end

endmodule

// ----- hw/rtl/fpfa_fit_cmp.sv -----
// ----------------------------------------------------------------------------
// Fit compare unit
// Shared compare stage: checks one candidate partition against the request
// and decides whether it replaces the current pick under the active mode.
// ----------------------------------------------------------------------------
module fpfa_fit_cmp (
  input  fpfa_pkg::fit_cmp_req_t req,
  output fpfa_pkg::fit_cmp_rsp_t rsp
);
  import fpfa_pkg::*;

  logic fits;

  // Free and large enough
  assign fits = !req.cand_busy && (req.cand_size >= req.req_size);

  // First and next fit keep the first hit; best/worst replace on strict win,
  // so ties stay with the earlier (lower) index
  always_comb begin
    rsp.fits = fits;
    unique case (req.mode)
      MODE_BEST:  rsp.take = fits && (!req.have_pick || req.cand_size < req.pick_size);
      MODE_WORST: rsp.take = fits && (!req.have_pick || req.cand_size > req.pick_size);
      MODE_FIRST,
      MODE_NEXT:  rsp.take = fits && !req.have_pick;
      default:    rsp.take = 1'b0;
    endcase
  end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Fixed partition fit allocator testbench
// Checks first, best, worst and next fit placement, partition release and
// the no-fit cases. A scoreboard model predicts each result when the input
// transfer happens. Directed cases run first, then randomized traffic over
// several capacity and mode settings, with random stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
  import fpfa_pkg::*;

  typedef struct packed {
    logic              success;
    logic [IDX_W-1:0]  part_index;
    logic [SIZE_W-1:0] part_size;
  } alloc_result_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // Block ports, all driven to known values from time zero
  logic                  cfg_we    = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [SIZE_W-1:0]     cfg_data  = '0;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;  // req_size[15:0], free_index[18:16]
  logic                  s_tuser   = 1'b0; // func
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;          // success[0], part_index[3:1],
                                           // part_size[19:4]

  // Scoreboard state
  alloc_result_t     pending_results[$];
  int                error_count = 0;
  bit                zero_gaps   = 1'b0;

  // Allocator model state, initialized to the reset values
  fit_mode_t         model_mode = MODE_FIRST;
  part_sizes_t       model_caps = {16'd622, 16'd202, 16'd102, 16'd200, 16'd100};
  logic [NUM_PARTS-1:0] model_busy = '0;
  logic [SIZE_W-1:0] model_held [NUM_PARTS] = '{default: '0};
  logic [IDX_W-1:0]  model_next = '0;

  fixed_partition_fit_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A partition can take the request if it is free and large enough
  function automatic bit partition_fits(int p, logic [SIZE_W-1:0] req);
    return !model_busy[p] && (model_caps[p] >= req);
  endfunction

  // Predict one result and advance the allocator model
  function automatic alloc_result_t predict_result(logic func, logic [SIZE_W-1:0] req,
                                                   logic [IDX_W-1:0] idx);
    alloc_result_t r;
    int pick;
    int start;
    int p;
    r = '0;
    pick = -1;
    if (func == FUNC_FREE) begin
      if (idx < NUM_PARTS) begin
        model_busy[idx] = 1'b0;
        model_held[idx] = '0;
        r.success    = 1'b1;
        r.part_index = idx;
        r.part_size  = model_caps[idx];
      end
      return r;
    end
    case (model_mode)
      MODE_BEST: begin
        for (p = 0; p < NUM_PARTS; p++)
          if (partition_fits(p, req) && (pick < 0 || model_caps[p] < model_caps[pick]))
            pick = p;
      end
      MODE_WORST: begin
        for (p = 0; p < NUM_PARTS; p++)
          if (partition_fits(p, req) && (pick < 0 || model_caps[p] > model_caps[pick]))
            pick = p;
      end
      MODE_NEXT: begin
        // stale start pointer falls back to partition 0
        start = (model_next < NUM_PARTS) ? int'(model_next) : 0;
        for (int k = 0; k < NUM_PARTS; k++) begin
          p = (start + k) % NUM_PARTS;
          if (pick < 0 && partition_fits(p, req))
            pick = p;
        end
        if (pick >= 0)
          model_next = IDX_W'(pick);
      end
      default: begin
        for (p = 0; p < NUM_PARTS; p++)
          if (pick < 0 && partition_fits(p, req))
            pick = p;
      end
    endcase
    if (pick >= 0) begin
      model_busy[pick] = 1'b1;
      model_held[pick] = req;
      r.success    = 1'b1;
      r.part_index = IDX_W'(pick);
      r.part_size  = model_caps[pick];
    end
    return r;
  endfunction

  // Send one item; valid stays high when the next item follows with no gap
  task automatic send_item(logic func, logic [SIZE_W-1:0] req, logic [IDX_W-1:0] idx);
    int gap;
    gap = zero_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {5'b0, idx, req};
    do @(posedge clk); while (s_tready !== 1'b1);
    pending_results.push_back(predict_result(func, req, idx));
  endtask

  task automatic alloc_req(logic [SIZE_W-1:0] req);
    send_item(FUNC_ALLOC, req, IDX_W'($urandom_range(0, 7)));
  endtask

  task automatic free_part(logic [IDX_W-1:0] idx);
    send_item(FUNC_FREE, SIZE_W'($urandom_range(0, 65535)), idx);
  endtask

  // Stop sending and wait until every expected result has come back
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write mode and all five capacities; only called while idle
  task automatic apply_config(fit_mode_t mode, part_sizes_t caps);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FIT_MODE;
    cfg_data  <= SIZE_W'(mode);
    @(posedge clk);
    for (int i = 0; i < NUM_PARTS; i++) begin
      cfg_index <= REG_SIZE_BASE + IDX_W'(i);
      cfg_data  <= caps[i];
      @(posedge clk);
    end
    cfg_we     <= 1'b0;
    model_mode = mode;
    model_caps = caps;
  endtask

  // Result side: random stall per result, then compare against the oldest prediction
  always begin : result_check
    int gap;
    alloc_result_t got;
    alloc_result_t want;
    gap = zero_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      m_tready <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    m_tready <= 1'b1;
    do @(posedge clk); while (rst || m_tvalid !== 1'b1);
    got.success    = m_tdata[0];
    got.part_index = m_tdata[3:1];
    got.part_size  = m_tdata[19:4];
    if (pending_results.size() == 0) begin
      $error("result transfer with no prediction waiting: %h", m_tdata);
      error_count++;
    end else begin
      want = pending_results.pop_front();
      if (got.success !== want.success) begin
        $error("success: expected %0d, got %0d", want.success, got.success);
        error_count++;
      end
      if (got.part_index !== want.part_index) begin
        $error("part_index: expected %0d, got %0d", want.part_index, got.part_index);
        error_count++;
      end
      if (got.part_size !== want.part_size) begin
        $error("part_size: expected %0d, got %0d", want.part_size, got.part_size);
        error_count++;
      end
    end
  end

  // Reset capacities: oversize request, zero-size request, bad frees and a free of an idle partition
  task automatic test_first_fit_defaults();
    alloc_req(16'd101);
    alloc_req(16'd0);
    alloc_req(16'hFFFF);
    free_part(3'd7);
    free_part(3'd5);
    free_part(3'd2);
    free_part(3'd0);
    free_part(3'd1);
    wait_drain();
  endtask

  // Best fit with a zero capacity partition and a tie between two equal ones
  task automatic test_best_fit_ties();
    apply_config(MODE_BEST, {16'd50, 16'd300, 16'hFFFF, 16'd300, 16'd0});
    alloc_req(16'd0);
    alloc_req(16'd40);
    alloc_req(16'd200);
    alloc_req(16'd200);
    alloc_req(16'hFFFF);
    alloc_req(16'd1);
    wait_drain();
  endtask

  // Worst fit after releasing some partitions
  task automatic test_worst_fit();
    apply_config(MODE_WORST, {16'd50, 16'd300, 16'hFFFF, 16'd300, 16'd0});
    free_part(3'd1);
    free_part(3'd2);
    free_part(3'd3);
    alloc_req(16'd10);
    alloc_req(16'd10);
    wait_drain();
  endtask

  // Next fit: pointer moves to the grant, search wraps past the last partition
  task automatic test_next_fit_wrap();
    apply_config(MODE_NEXT, {16'd50, 16'd300, 16'hFFFF, 16'd300, 16'd0});
    alloc_req(16'd10);
    free_part(3'd0);
    alloc_req(16'd0);
    wait_drain();
  endtask

  // Request sizes mostly near a current capacity so fits and misses both happen
  function automatic logic [SIZE_W-1:0] draw_request();
    int v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = 65535;
      2, 3:    v = $urandom_range(0, 65535);
      default: begin
        v = int'(model_caps[$urandom_range(0, NUM_PARTS - 1)]) + $urandom_range(0, 4) - 2;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end
    endcase
    return SIZE_W'(v);
  endfunction

  function automatic part_sizes_t draw_capacities(int style);
    part_sizes_t caps;
    logic [SIZE_W-1:0] same;
    same = SIZE_W'($urandom_range(0, 700));
    for (int i = 0; i < NUM_PARTS; i++)
      case (style)
        0:       caps[i] = $urandom_range(0, 1) ? SIZE_W'(65535 - $urandom_range(0, 1))
                                                : SIZE_W'($urandom_range(0, 1));
        1:       caps[i] = same;
        2:       caps[i] = SIZE_W'($urandom_range(0, 700));
        default: caps[i] = SIZE_W'($urandom_range(0, 65535));
      endcase
    return caps;
  endfunction

  // Random allocate/free traffic over every mode and several capacity layouts
  task automatic test_random_traffic();
    for (int phase = 0; phase < 8; phase++) begin
      apply_config(fit_mode_t'((phase + phase / 4) % 4), draw_capacities(phase % 4));
      zero_gaps = (phase == 3 || phase == 6);
      for (int n = 0; n < 230; n++) begin
        if ($urandom_range(0, 99) < 40)
          free_part(($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(5, 7))
                                                : IDX_W'($urandom_range(0, NUM_PARTS - 1)));
        else
          alloc_req(draw_request());
      end
      wait_drain();
      zero_gaps = 1'b0;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_first_fit_defaults();
    test_best_fit_ties();
    test_worst_fit();
    test_next_fit_wrap();
    test_random_traffic();
    wait_drain();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Run limit
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule
